// ===== rtl/core/bbl_pkg.sv =====
package bbl_pkg;

  localparam int unsigned CfgW = 12;
  localparam int unsigned RowW = 13;
  localparam int unsigned PixW = 24;
  localparam int unsigned SumW = 12;
  localparam int unsigned CntW = 4;
  localparam int unsigned Taps = 9;

  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  localparam logic [CfgW-1:0] FrameWidthRst  = 12'd640;
  localparam logic [CfgW-1:0] FrameHeightRst = 12'd480;

  // x/3 and x/9 by reciprocal, exact for x below 2^12
  localparam logic [11:0] Recip3 = 12'd2731;
  localparam logic [11:0] Recip9 = 12'd3641;
  localparam int unsigned Shift3 = 13;
  localparam int unsigned Shift9 = 15;

  typedef struct packed {
    logic [Taps-1:0] mask;
    logic [CntW-1:0] cnt;
  } win_ctl_t;

  typedef struct packed {
    logic [PixW-1:0] px;
    logic            has_res;
    logic            fend;
    win_ctl_t        ctl;
  } s1_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } pix_res_t;

  function automatic logic [7:0] div_small(input logic [SumW-1:0] x,
                                           input logic [CntW-1:0] n);
    logic [23:0]     p3;
    logic [23:0]     p9;
    logic [SumW-1:0] q;
    p3 = 24'(x) * 24'(Recip3);
    p9 = 24'(x) * 24'(Recip9);
    unique case (n)
      4'd2:    q = x >> 1;
      4'd3:    q = SumW'(p3 >> Shift3);
      4'd4:    q = x >> 2;
      4'd6:    q = SumW'(p3 >> (Shift3 + 1));
      4'd9:    q = SumW'(p9 >> Shift9);
      default: q = x;
    endcase
    return q[7:0];
  endfunction

endpackage

// ===== rtl/core/box_blur_3x3_rgb_core.sv =====
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | kind_i, in_red_i, in_green_i, in_blue_i
// out     | output    | out_valid_o / out_ready_i | out_red_o, out_green_o, out_blue_o,
//         |           |                           | frame_end_o
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the skid stage is empty; a result passes the stage-1, window, lane-sum and output registers.
// The result for a pixel is caused by the item one row plus one pixel later in the stream.
// The line buffer is one read and one write port, shared by both stored rows (48-bit entries).
// Line buffer contents are undefined after reset; no clearing pass.
// in_ready_o drops only while the skid stage holds an item; the pipeline then freezes.
module box_blur_3x3_rgb_core import bbl_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            kind_i,
  input  logic [7:0]      in_red_i,
  input  logic [7:0]      in_green_i,
  input  logic [7:0]      in_blue_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o,
  output logic            frame_end_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW > CfgW) ? AW : CfgW;

  logic [CfgW-1:0] frame_width_q, frame_height_q;
  logic [CfgW-1:0] w_eff, h_eff;
  logic [RowW-1:0] h13;
  logic [AW-1:0]   col_d, col_q;
  logic [RowW-1:0] row_d, row_q;
  logic [CW-1:0]   col_ext, w_ext;

  logic en, accept, tail, ignore, c0, last_col;
  logic row0v, row2v, col0v, col2v;
  logic [1:0] rows_n, cols_n;
  logic [2:0] rowv, colv;
  s1_t  s1_d, s1_q;
  logic s1_valid_q;
  logic [AW-1:0] s1_addr_q;

  logic [2*PixW-1:0] rd_data, wr_data;
  logic [PixW-1:0]   a_old, b_old;

  logic [2:0][2:0][PixW-1:0] win_q;
  logic     s2_valid_q, s2_fend_q;
  win_ctl_t s2_ctl_q;
  logic     s3_valid_q, s3_fend_q;

  logic [2:0][Taps-1:0][7:0] lane_tap;
  logic [2:0][7:0]           lane_avg;
  pix_res_t res, out_res;
  logic     skid_full;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = CfgW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = CfgW'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_q;
    end
    h_eff = (frame_height_q == '0) ? CfgW'(1) : frame_height_q;
  end

  assign h13     = RowW'(h_eff);
  assign col_ext = CW'(col_q);
  assign w_ext   = CW'(w_eff);

  assign en     = !skid_full;
  assign accept = in_valid_i && en;
  assign tail   = row_q >= h13;
  assign ignore = kind_i && !tail;
  assign c0     = (col_q == '0);
  assign last_col = (col_ext + CW'(1) == w_ext);

  // centre row is two rows back at column zero, else one row back
  assign row0v = c0 ? (row_q >= RowW'(3)) : (row_q >= RowW'(2));
  assign row2v = c0 ? (row_q <= h13) : (row_q < h13);
  assign col0v = c0 ? (w_eff >= CfgW'(2)) : (col_ext >= CW'(2));
  assign col2v = !c0;
  assign rowv  = {row2v, 1'b1, row0v};
  assign colv  = {col2v, 1'b1, col0v};
  assign rows_n = 2'd1 + 2'(row0v) + 2'(row2v);
  assign cols_n = 2'd1 + 2'(col0v) + 2'(col2v);

  always_comb begin
    s1_d.px      = tail ? '0 : {in_blue_i, in_green_i, in_red_i};
    s1_d.has_res = c0 ? (row_q >= RowW'(2)) : (row_q >= RowW'(1));
    s1_d.fend    = c0 && (row_q == h13 + RowW'(1));
    s1_d.ctl.cnt = CntW'(rows_n) * CntW'(cols_n);
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        s1_d.ctl.mask[k*3+j] = rowv[k] & colv[j];
      end
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (s1_d.fend) begin
      col_d = '0;
      row_d = '0;
    end else if (last_col) begin
      col_d = '0;
      row_d = row_q + RowW'(1);
    end else begin
      col_d = col_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
      col_q          <= '0;
      row_q          <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrameWidth:  frame_width_q  <= cfg_wdata_i;
        CfgFrameHeight: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (accept && !ignore) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept && !ignore;
      s2_valid_q <= s1_valid_q && s1_q.has_res;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !ignore) begin
      s1_q      <= s1_d;
      s1_addr_q <= col_q;
    end
    if (en) begin
      s2_ctl_q  <= s1_q.ctl;
      s2_fend_q <= s1_q.fend;
      s3_fend_q <= s2_fend_q;
    end
    if (en && s1_valid_q) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= b_old;
      win_q[1][2] <= a_old;
      win_q[2][2] <= s1_q.px;
    end
  end

  assign {b_old, a_old} = rd_data;
  assign wr_data        = {a_old, s1_q.px};

  bbl_line_buf #(
    .DEPTH(MAX_WIDTH),
    .AW   (AW)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept && !ignore),
    .rd_addr_i(col_q),
    .wr_en_i  (en && s1_valid_q),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          lane_tap[ch][k*3+j] = win_q[k][j][8*ch +: 8];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    bbl_chan_lane u_lane (
      .clk_i(clk_i),
      .en_i (en),
      .tap_i(lane_tap[ch]),
      .ctl_i(s2_ctl_q),
      .avg_o(lane_avg[ch])
    );
  end

  assign res.red   = lane_avg[0];
  assign res.green = lane_avg[1];
  assign res.blue  = lane_avg[2];
  assign res.fend  = s3_fend_q;

  bbl_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (en && s3_valid_q),
    .in_res_i   (res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res),
    .full_o     (skid_full)
  );

  assign in_ready_o  = en;
  assign out_red_o   = out_res.red;
  assign out_green_o = out_res.green;
  assign out_blue_o  = out_res.blue;
  assign frame_end_o = out_res.fend;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ext < w_ext)
    else $error("column counter beyond frame width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h13 + RowW'(1))
    else $error("row counter beyond frame tail");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.fend |-> s1_q.has_res)
    else $error("frame end flagged on an item without result");

endmodule

// ===== rtl/core/bbl_line_buf.sv =====
module bbl_line_buf import bbl_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [2*PixW-1:0] wr_data_i,
  output logic [2*PixW-1:0] rd_data_o
);

  logic [2*PixW-1:0] mem [DEPTH];
  logic [2*PixW-1:0] rd_q;
  logic [2*PixW-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // same-address read and write in one cycle (one-pixel rows)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/core/bbl_chan_lane.sv =====
module bbl_chan_lane import bbl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [Taps-1:0][7:0] tap_i,
  input  win_ctl_t             ctl_i,
  output logic [7:0]           avg_o
);

  logic [SumW-1:0] sum_d, sum_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] rnd;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < Taps; i++) begin
      sum_d = sum_d + (ctl_i.mask[i] ? SumW'(tap_i[i]) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
      cnt_q <= ctl_i.cnt;
    end
  end

  assign rnd   = sum_q + SumW'(cnt_q >> 1);
  assign avg_o = div_small(rnd, cnt_q);

endmodule

// ===== rtl/core/bbl_out_stage.sv =====
module bbl_out_stage import bbl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  pix_res_t in_res_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_res_t out_res_o,
  output logic     full_o
);

  logic     out_valid_d, out_valid_q;
  logic     skid_full_d, skid_full_q;
  pix_res_t out_d, out_q;
  pix_res_t skid_d, skid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    out_d       = out_q;
    skid_d      = skid_q;
    priority if (skid_full_q) begin
      if (out_ready_i) begin
        out_d       = skid_q;
        skid_full_d = 1'b0;
      end
    end else if (in_valid_i) begin
      if (!out_valid_q || out_ready_i) begin
        out_d       = in_res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d      = in_res_i;
        skid_full_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign full_o      = skid_full_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid holds an item behind an empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q && out_ready_i |=> !skid_full_q && out_valid_q)
    else $error("skid item not moved to output");

endmodule
